// File: rtl/split_free_list_block_allocator_assert.svh
// assertion macros for the split free-list block allocator
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SPLIT_FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define SPLIT_FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SFLBA_ASSERT_IMP(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error("allocator check failed");

// condition holds in the cycle after the trigger
`define SFLBA_ASSERT_NXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error("allocator check failed");

`endif

// File: rtl/sflba_pkg.sv
// shared types and constants of the split free-list block allocator
// no dependencies
`timescale 1ns / 1ps

package sflba_pkg;

    localparam int ADDR_W      = 12;
    localparam int ADDR_UNITS  = 1 << ADDR_W;
    localparam int LEVEL_W     = 3;
    localparam int LEVELS_DEF  = 8;
    localparam int CHUNKS_DEF  = 16;

    // list entry: valid flag plus unit address
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    // write request to the list head registers
    typedef struct packed {
        logic  en;
        t_link data;
    } t_head_wr;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SPLIT,
        S_DONE
    } t_state;

endpackage

// File: rtl/sflba_if.sv
// valid/ready channel interfaces for requests and responses
// depends on sflba_pkg
`timescale 1ns / 1ps

interface sflba_req_if import sflba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [LEVEL_W-1:0] size_level;
    logic [ADDR_W-1:0]  block_address;

    modport source (output valid, action, size_level, block_address, input ready);
    modport sink   (input valid, action, size_level, block_address, output ready);
endinterface

interface sflba_rsp_if import sflba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_address;
    logic              success;

    modport source (output valid, granted_address, success, input ready);
    modport sink   (input valid, granted_address, success, output ready);
endinterface

// File: rtl/sflba_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sflba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sflba_heads.sv
// free-list head registers, one per level, with search for a non-empty list
// depends on sflba_pkg
`timescale 1ns / 1ps

module sflba_heads import sflba_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF,
    parameter int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_head_wr           i_wr,
    input  logic [LVL_W-1:0]   i_wr_idx,
    input  logic [LVL_W-1:0]   i_rd_idx,
    output t_link              o_rd_data,
    input  logic [LEVEL_W-1:0] i_lvl,
    output logic               o_found,
    output logic [LVL_W-1:0]   o_found_idx
);

    t_link r_head [LEVELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_head[i_wr_idx] <= i_wr.data;
        end
    end

    assign o_rd_data = r_head[i_rd_idx];

    // lowest non-empty list at or above the requested level
    always_comb begin
        o_found     = 1'b0;
        o_found_idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (i >= int'(i_lvl) && r_head[i].vld) begin
                o_found     = 1'b1;
                o_found_idx = LVL_W'(i);
            end
        end
    end

endmodule

// File: rtl/split_free_list_block_allocator.sv
// Split free-list block allocator. Requests arrive on i_req (allocate or free
// a block of 2^size_level units) and each one yields exactly one response on
// o_rsp. One free list per level is kept as a head register plus a 4096-entry
// link memory; allocate pops the exact level, else the lowest non-empty higher
// level, else a fresh chunk of 2^LEVELS units, and splits it down, pushing each
// lower half onto its list and handing out the upper half. Free pushes the
// block as given and never merges. A free, a bad level or an allocate with no
// block left goes from accept straight to S_DONE and the response load; an
// exact-level allocate first pops the head in S_POP; a block popped from a
// higher list is then split one level per S_SPLIT step, and a fresh chunk
// goes straight to the S_SPLIT steps. The next request is taken as soon
// as the response is in the output register, even while it waits to be
// transferred. The link memory needs no clearing after reset: every link is
// written before it can be read. Depends on sflba_pkg, sflba_if, sflba_ram and
// sflba_heads.
`timescale 1ns / 1ps

module split_free_list_block_allocator import sflba_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF,
    parameter int CHUNKS = CHUNKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sflba_req_if.sink   i_req,
    sflba_rsp_if.source o_rsp
);

`include "split_free_list_block_allocator_assert.svh"

    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int B_W        = $clog2(LEVELS + 1);
    // chunks that fit both the chunk budget and the address space
    localparam int FIT_CHUNKS = (LEVELS > ADDR_W) ? 0 : (ADDR_UNITS >> LEVELS);
    localparam int MAX_CHUNKS = (CHUNKS < FIT_CHUNKS) ? CHUNKS : FIT_CHUNKS;
    localparam int CNT_W      = (MAX_CHUNKS > 0) ? $clog2(MAX_CHUNKS + 1) : 1;

    t_state            r_state, n_state;
    logic [LVL_W-1:0]  r_lvl, n_lvl;        // requested level
    logic [B_W-1:0]    r_b, n_b;            // level of block being split
    logic [ADDR_W-1:0] r_blk, n_blk;        // current block address
    logic [CNT_W-1:0]  r_chunks, n_chunks;  // fresh chunks taken
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic              r_res_ok, n_res_ok;
    logic              r_out_vld, n_out_vld;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic              r_out_ok, n_out_ok;

    // request decode
    logic              req_xfer;
    logic              lvl_ok;
    logic [LVL_W-1:0]  lvl_idx;
    logic              is_free;
    logic              chunk_ok;
    logic              out_free;

    // split step
    logic [B_W-1:0]    nb;
    logic [LVL_W-1:0]  nb_idx;
    logic [ADDR_W-1:0] half_step;

    // head registers and link memory
    t_head_wr          head_wr;
    logic [LVL_W-1:0]  head_wr_idx;
    logic [LVL_W-1:0]  head_rd_idx;
    t_link             head_rd;
    logic              found;
    logic [LVL_W-1:0]  found_idx;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [LINK_W-1:0] ram_rdata;

    assign req_xfer  = i_req.valid && i_req.ready;
    assign lvl_ok    = int'(i_req.size_level) < LEVELS;
    assign lvl_idx   = LVL_W'(i_req.size_level);
    assign is_free   = i_req.action == ACT_FREE;
    assign chunk_ok  = int'(r_chunks) < MAX_CHUNKS;
    assign out_free  = !r_out_vld || o_rsp.ready;
    assign nb        = r_b - B_W'(1);
    assign nb_idx    = nb[LVL_W-1:0];
    assign half_step = ADDR_W'(1) << nb;

    sflba_heads #(
        .LEVELS (LEVELS),
        .LVL_W  (LVL_W)
    ) u_heads (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (head_wr),
        .i_wr_idx    (head_wr_idx),
        .i_rd_idx    (head_rd_idx),
        .o_rd_data   (head_rd),
        .i_lvl       (i_req.size_level),
        .o_found     (found),
        .o_found_idx (found_idx)
    );

    sflba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (ADDR_UNITS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (head_rd.addr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    if (lvl_ok && !is_free && found) begin
                        n_state = S_POP;
                    end else if (lvl_ok && !is_free && chunk_ok) begin
                        n_state = S_SPLIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_POP: begin
                n_state = (r_b == B_W'(r_lvl)) ? S_DONE : S_SPLIT;
            end
            S_SPLIT: begin
                if (nb == B_W'(r_lvl)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: handshake, head register and link memory controls
    always_comb begin
        i_req.ready  = r_state == S_IDLE;
        head_wr      = '0;
        head_wr_idx  = lvl_idx;
        head_rd_idx  = is_free ? lvl_idx : found_idx;
        ram_we       = 1'b0;
        ram_waddr    = i_req.block_address;
        ram_wdata    = head_rd;
        ram_re       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_xfer && lvl_ok) begin
                    if (is_free) begin
                        // push: new block links to the old head
                        ram_we            = 1'b1;
                        head_wr.en        = 1'b1;
                        head_wr.data.vld  = 1'b1;
                        head_wr.data.addr = i_req.block_address;
                    end else if (found) begin
                        // pop: fetch the link of the head block
                        ram_re = 1'b1;
                    end
                end
            end
            S_POP: begin
                head_wr.en  = 1'b1;
                head_wr.data = t_link'(ram_rdata);
                head_wr_idx = r_b[LVL_W-1:0];
            end
            S_SPLIT: begin
                // lower half goes onto the list one level down
                head_rd_idx       = nb_idx;
                head_wr_idx       = nb_idx;
                head_wr.en        = 1'b1;
                head_wr.data.vld  = 1'b1;
                head_wr.data.addr = r_blk;
                ram_we            = 1'b1;
                ram_waddr         = r_blk;
            end
            default: begin
            end
        endcase
    end

    // datapath registers
    always_comb begin
        n_lvl      = r_lvl;
        n_b        = r_b;
        n_blk      = r_blk;
        n_chunks   = r_chunks;
        n_res_addr = r_res_addr;
        n_res_ok   = r_res_ok;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out_addr = r_out_addr;
        n_out_ok   = r_out_ok;
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_lvl      = lvl_idx;
                    n_res_addr = '0;
                    n_res_ok   = lvl_ok && is_free;
                    if (lvl_ok && !is_free && found) begin
                        n_b   = B_W'(found_idx);
                        n_blk = head_rd.addr;
                    end else if (lvl_ok && !is_free && chunk_ok) begin
                        n_b      = B_W'(LEVELS);
                        n_blk    = ADDR_W'(r_chunks) << LEVELS;
                        n_chunks = r_chunks + CNT_W'(1);
                    end
                end
            end
            S_POP: begin
                n_res_addr = r_blk;
                n_res_ok   = 1'b1;
            end
            S_SPLIT: begin
                n_b        = nb;
                n_blk      = r_blk + half_step;
                n_res_addr = r_blk + half_step;
                n_res_ok   = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_addr = r_res_addr;
                    n_out_ok   = r_res_ok;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chunks  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chunks  <= n_chunks;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_b        <= n_b;
        r_blk      <= n_blk;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
        r_out_addr <= n_out_addr;
        r_out_ok   <= n_out_ok;
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.granted_address = r_out_addr;
    assign o_rsp.success         = r_out_ok;

    // a failed request never reports an address
    `SFLBA_ASSERT_IMP(a_fail_addr_zero, o_rsp.valid && !o_rsp.success, o_rsp.granted_address == '0)
    // splitting always stays above the requested level
    `SFLBA_ASSERT_IMP(a_split_above_req, r_state == S_SPLIT, r_b > B_W'(r_lvl))
    // fresh chunk count stays within the pool
    `SFLBA_ASSERT_IMP(a_chunks_bounded, 1'b1, int'(r_chunks) <= MAX_CHUNKS)
    // a free finishes without touching the split path
    `SFLBA_ASSERT_NXT(a_free_short, req_xfer && is_free, r_state == S_DONE)

endmodule

// File: tb/split_free_list_block_allocator_tb.sv
// self-checking bench for the split free-list block allocator: directed and random
// allocate/free traffic with idle and stall phases, checked against a free-list predictor
// depends on sflba_pkg, sflba_if and split_free_list_block_allocator
`timescale 1ns / 1ps

// one expected response and one block handed out by the allocator
typedef struct packed {
    logic [sflba_pkg::ADDR_W-1:0] addr;
    logic                         success;
} t_grant;

typedef struct packed {
    logic [sflba_pkg::LEVEL_W-1:0] level;
    logic [sflba_pkg::ADDR_W-1:0]  addr;
} t_held;

// free-list predictor plus the queue of grants still to be seen on the response side
class alloc_scoreboard #(int LEVELS = 8, int CHUNKS = 16);
    localparam int CHUNK_UNITS = 1 << LEVELS;

    sflba_pkg::t_link heads [8];
    sflba_pkg::t_link links [sflba_pkg::ADDR_UNITS];
    int unsigned      chunks_used;
    t_grant           expected_grants [$];
    t_held            held_blocks [$];
    int unsigned      mismatches;

    function void clear();
        foreach (heads[i]) heads[i] = '0;
        foreach (links[i]) links[i] = '0;
        chunks_used = 0;
        mismatches  = 0;
    endfunction

    function void push_free(int lvl, logic [sflba_pkg::ADDR_W-1:0] addr);
        links[addr] = heads[lvl];
        heads[lvl]  = '{vld: 1'b1, addr: addr};
    endfunction

    function logic [sflba_pkg::ADDR_W-1:0] pop_free(int lvl);
        logic [sflba_pkg::ADDR_W-1:0] addr;
        addr       = heads[lvl].addr;
        heads[lvl] = links[addr];
        return addr;
    endfunction

    // work out the grant caused by one accepted request
    function void note_request(sflba_pkg::t_action act, logic [sflba_pkg::LEVEL_W-1:0] level,
                               logic [sflba_pkg::ADDR_W-1:0] addr);
        t_grant                       g;
        int                           b;
        bit                           have_block;
        logic [sflba_pkg::ADDR_W-1:0] blk;
        g = '{addr: '0, success: 1'b0};
        if (level < LEVELS) begin
            if (act == sflba_pkg::ACT_FREE) begin
                push_free(level, addr);
                g.success = 1'b1;
            end else if (heads[level].vld) begin
                g.addr    = pop_free(level);
                g.success = 1'b1;
            end else begin
                have_block = 1'b0;
                for (b = level + 1; b < LEVELS; b++) begin
                    if (heads[b].vld) begin
                        have_block = 1'b1;
                        break;
                    end
                end
                blk = '0;
                if (have_block) begin
                    blk = pop_free(b);
                end else if (chunks_used < CHUNKS &&
                             (chunks_used + 1) * CHUNK_UNITS <= sflba_pkg::ADDR_UNITS) begin
                    blk = sflba_pkg::ADDR_W'(chunks_used * CHUNK_UNITS);
                    chunks_used++;
                    b = LEVELS;
                    have_block = 1'b1;
                end
                if (have_block) begin
                    // lower halves go back on the lists, upper half moves on
                    do begin
                        b--;
                        push_free(b, blk);
                        blk = blk + sflba_pkg::ADDR_W'(1 << b);
                    end while (b > level);
                    g.addr    = blk;
                    g.success = 1'b1;
                end
            end
            if (act == sflba_pkg::ACT_ALLOC && g.success)
                held_blocks.push_back('{level: level, addr: g.addr});
        end
        expected_grants.push_back(g);
    endfunction

    function void check_grant(logic [sflba_pkg::ADDR_W-1:0] addr, logic success);
        t_grant want;
        if (expected_grants.size() == 0) begin
            $error("response with nothing expected: granted_address %0h success %0b",
                   addr, success);
            mismatches++;
            return;
        end
        want = expected_grants.pop_front();
        if (addr !== want.addr) begin
            $error("granted_address: expected %0h, actual %0h", want.addr, addr);
            mismatches++;
        end
        if (success !== want.success) begin
            $error("success: expected %0b, actual %0b", want.success, success);
            mismatches++;
        end
    endfunction
endclass

module split_free_list_block_allocator_tb;
    import sflba_pkg::*;

    localparam int LEVELS        = 8;
    localparam int CHUNKS        = 16;
    localparam int PHASE_ITEMS   = 385;
    // covers the longest allocate, plus slack for the output register
    localparam int SETTLE_CYCLES = LEVELS + 12;
    // upper bound on the whole run for the watchdog
    localparam int CYCLE_LIMIT   = 400000;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned alloc_pct;
    int unsigned cycle_count;

    sflba_req_if req_bus ();
    sflba_rsp_if rsp_bus ();

    alloc_scoreboard #(.LEVELS(LEVELS), .CHUNKS(CHUNKS)) sb;

    split_free_list_block_allocator #(
        .LEVELS (LEVELS),
        .CHUNKS (CHUNKS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    // response side: ready is drawn anew at each falling edge with the phase's stall rate
    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // every response transfer is checked against the oldest expected grant
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_grant(rsp_bus.granted_address, rsp_bus.success);
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one request transfer; entered and left at a falling edge
    task automatic send_request(t_action act, logic [LEVEL_W-1:0] level,
                                logic [ADDR_W-1:0] addr);
        // random idle cycles ahead of the item, valid held low
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.action        <= act;
        req_bus.size_level    <= level;
        req_bus.block_address <= addr;
        do @(posedge i_clk); while (!req_bus.ready);
        // transfer taken at this edge: predict before the next item is picked
        sb.note_request(act, level, addr);
        @(negedge i_clk);
    endtask

    // hold off the request side until every expected grant has come back
    task automatic drain_grants();
        req_bus.valid <= 1'b0;
        do @(negedge i_clk); while (sb.expected_grants.size() != 0);
    endtask

    // mostly well-formed traffic: allocations and frees of blocks actually held,
    // with a share of arbitrary frees at any address and level
    task automatic run_random(int count);
        int unsigned pick;
        int          idx;
        t_held       h;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick >= 88) begin
                send_request(ACT_FREE, LEVEL_W'($urandom_range(0, 7)),
                             ADDR_W'($urandom_range(0, ADDR_UNITS - 1)));
            end else if (pick < alloc_pct || sb.held_blocks.size() == 0) begin
                send_request(ACT_ALLOC, LEVEL_W'($urandom_range(0, 7)),
                             ADDR_W'($urandom_range(0, ADDR_UNITS - 1)));
            end else begin
                idx = $urandom_range(0, sb.held_blocks.size() - 1);
                h   = sb.held_blocks[idx];
                sb.held_blocks.delete(idx);
                send_request(ACT_FREE, h.level, h.addr);
            end
        end
    endtask

    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        cycle_count           = 0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        alloc_pct             = 70;
        req_bus.valid         = 1'b0;
        req_bus.action        = ACT_ALLOC;
        req_bus.size_level    = '0;
        req_bus.block_address = '0;
        rsp_bus.ready         = 1'b0;
        sb = new;
        sb.clear();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, no idling
        // unaligned free at the top of the address space, then a split of it
        // wraps the upper halves around past address zero
        send_request(ACT_FREE,  3'd7, 12'hFFF);
        send_request(ACT_ALLOC, 3'd0, 12'h000);
        // a fresh chunk, then the largest level popped straight off its list
        send_request(ACT_ALLOC, 3'd7, 12'hFFF);
        send_request(ACT_ALLOC, 3'd7, 12'h000);
        for (int lvl = 0; lvl < LEVELS; lvl++)
            send_request(ACT_ALLOC, LEVEL_W'(lvl), 12'h5A5);
        // double free of one block, then both copies handed out again
        send_request(ACT_FREE,  3'd3, 12'h000);
        send_request(ACT_FREE,  3'd3, 12'h000);
        send_request(ACT_ALLOC, 3'd3, 12'h000);
        send_request(ACT_ALLOC, 3'd3, 12'h000);
        // frees of arbitrary addresses, no ownership check
        send_request(ACT_FREE,  3'd0, 12'hABC);
        send_request(ACT_FREE,  3'd5, 12'h555);
        send_request(ACT_ALLOC, 3'd5, 12'hFFF);
        send_request(ACT_ALLOC, 3'd0, 12'h000);
        send_request(ACT_FREE,  3'd7, 12'h000);
        drain_grants();

        // random phases; the first leans on allocation to run the pool dry
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain_grants();

        alloc_pct      = 55;
        send_idle_pct  = 69;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain_grants();

        send_idle_pct  = 0;
        recv_stall_pct = 69;
        run_random(PHASE_ITEMS);
        drain_grants();

        send_idle_pct  = 6;
        recv_stall_pct = 6;
        run_random(PHASE_ITEMS);
        drain_grants();

        // let any stray response show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/sflba_pkg.sv
rtl/sflba_if.sv
rtl/sflba_ram.sv
rtl/sflba_heads.sv
rtl/split_free_list_block_allocator.sv
tb/split_free_list_block_allocator_tb.sv
